// ----- hdl/vdtm_pkg.sv -----
package vdtm_pkg;

  localparam int ELEMENT_BITS  = 16;
  localparam int FRACTION_BITS = 12;
  localparam int ACC_BITS      = 48;
  localparam int PROD_BITS     = 2 * ELEMENT_BITS;
  localparam int OUT_FRAC      = 2 * FRACTION_BITS;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ONE_OUT = ACC_BITS'(64'd1 << OUT_FRAC);

  localparam logic [CFG_IDX_BITS-1:0] REG_KIND      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    KIND_COSINE = 2'd0,
    KIND_INNER  = 2'd1,
    KIND_L2     = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] dot;
    logic signed [ACC_BITS-1:0] qn;
    logic signed [ACC_BITS-1:0] rn;
  } sums_t;

  // saturating add of a product into a running sum
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0]  sum,
    input logic signed [PROD_BITS-1:0] prod
  );
    logic signed [ACC_BITS:0] wide;
    wide = {sum[ACC_BITS-1], sum} + (ACC_BITS+1)'(prod);
    if (wide[ACC_BITS] != wide[ACC_BITS-1]) begin
      return wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return wide[ACC_BITS-1:0];
  endfunction

endpackage

// ----- hdl/vdtm_front.sv -----
module vdtm_front import vdtm_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [ELEMENT_BITS-1:0] query_element,
  input  logic signed [ELEMENT_BITS-1:0] row_element,
  input  logic                           last_element,
  input  logic                           q_full,
  output logic                           q_wr,
  output sums_t                          q_data
);

  logic                        p_valid;
  logic                        p_last;
  logic signed [PROD_BITS-1:0] p_dot;
  logic signed [PROD_BITS-1:0] p_qn;
  logic signed [PROD_BITS-1:0] p_rn;
  sums_t                       sums;
  sums_t                       sums_next;
  logic                        advance;

  // product stage stalls only when it holds a last pair and the queue is full
  assign advance = !p_valid || !p_last || !q_full;
  assign full    = !advance;

  always_comb begin
    sums_next.dot = sat_add(sums.dot, p_dot);
    sums_next.qn  = sat_add(sums.qn, p_qn);
    sums_next.rn  = sat_add(sums.rn, p_rn);
  end

  assign q_wr   = p_valid && p_last && !q_full;
  assign q_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
      sums    <= '0;
    end else begin
      if (advance) begin
        p_valid <= push;
        if (push) begin
          p_last <= last_element;
          p_dot  <= query_element * row_element;
          p_qn   <= query_element * query_element;
          p_rn   <= row_element * row_element;
        end
      end
      if (p_valid && advance) begin
        sums <= p_last ? '0 : sums_next;
      end
    end
  end

endmodule

// ----- hdl/vdtm_queue.sv -----
module vdtm_queue import vdtm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  sums_t wr_data,
  output logic  is_full,
  input  logic  rd,
  output sums_t rd_data,
  output logic  is_empty
);

  sums_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign is_full  = count == 2'd2;
  assign is_empty = count == 2'd0;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr        <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- hdl/vdtm_back.sv -----
module vdtm_back import vdtm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  sums_t                      q_data,
  output logic                       q_rd,
  input  kind_t                      kind,
  input  logic signed [ACC_BITS-1:0] threshold,
  output logic                       empty,
  input  logic                       pop,
  output logic                       match,
  output logic signed [ACC_BITS-1:0] distance
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQRT, S_CHK, S_DIV, S_DONE
  } state_t;

  state_t                      state;
  logic [5:0]                  cnt;
  logic signed [ACC_BITS-1:0]  dot;
  logic [ACC_BITS-1:0]         mcand;
  logic [2*ACC_BITS:0]         prod;
  logic [ACC_BITS+2:0]         rem;
  logic [ACC_BITS-1:0]         root;
  logic [OUT_FRAC:0]           quo;
  logic signed [ACC_BITS-1:0]  fin_distance;
  logic                        out_valid;

  logic [ACC_BITS:0]           mul_sum;
  logic [ACC_BITS+2:0]         sq_shift;
  logic [ACC_BITS+2:0]         sq_trial;
  logic [ACC_BITS+2:0]         dv_shift;
  logic [ACC_BITS-1:0]         mag;
  logic [OUT_FRAC:0]           quo_next;
  logic signed [ACC_BITS+2:0]  l2_wide;
  logic                        out_load;

  always_comb begin
    mul_sum  = prod[2*ACC_BITS:ACC_BITS] + (prod[0] ? {1'b0, mcand} : '0);
    sq_shift = {rem[ACC_BITS:0], prod[2*ACC_BITS-1:2*ACC_BITS-2]};
    sq_trial = {1'b0, root, 2'b01};
    dv_shift = {rem[ACC_BITS+1:0], 1'b0};
    mag      = dot[ACC_BITS-1] ? ACC_BITS'(-dot) : ACC_BITS'(dot);
    quo_next = {quo[OUT_FRAC-1:0], (dv_shift >= {3'b0, root})};
    l2_wide  = (ACC_BITS+3)'(q_data.qn) + (ACC_BITS+3)'(q_data.rn)
             - ((ACC_BITS+3)'(q_data.dot) <<< 1);
  end

  assign q_rd     = state == S_IDLE && !q_empty;
  assign empty    = !out_valid;
  assign out_load = state == S_DONE && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        distance  <= fin_distance;
        match     <= fin_distance <= threshold;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            dot <= q_data.dot;
            case (kind)
              KIND_COSINE: begin
                if (q_data.qn <= 0 || q_data.rn <= 0) begin
                  fin_distance <= ONE_OUT;
                  state        <= S_DONE;
                end else begin
                  mcand <= ACC_BITS'(q_data.rn);
                  prod  <= {(ACC_BITS+1)'(0), q_data.qn};
                  cnt   <= '0;
                  state <= S_MUL;
                end
              end
              KIND_INNER: begin
                fin_distance <= (q_data.dot == ACC_MIN) ? ACC_MAX : -q_data.dot;
                state        <= S_DONE;
              end
              KIND_L2: begin
                if (l2_wide < 0) begin
                  fin_distance <= '0;
                end else if (l2_wide > (ACC_BITS+3)'(ACC_MAX)) begin
                  fin_distance <= ACC_MAX;
                end else begin
                  fin_distance <= l2_wide[ACC_BITS-1:0];
                end
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          // shift-add product of the two norm sums
          prod <= {1'b0, mul_sum, prod[ACC_BITS-1:1]};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(ACC_BITS-1)) begin
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // restoring square root, two product bits per step
          prod <= prod << 2;
          if (sq_shift >= sq_trial) begin
            rem  <= sq_shift - sq_trial;
            root <= {root[ACC_BITS-2:0], 1'b1};
          end else begin
            rem  <= sq_shift;
            root <= {root[ACC_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(ACC_BITS-1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (mag >= root) begin
            fin_distance <= dot[ACC_BITS-1] ? (ONE_OUT <<< 1) : '0;
            state        <= S_DONE;
          end else begin
            rem   <= (ACC_BITS+3)'(mag);
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide of |dot| by root, one quotient bit per step
          rem <= (dv_shift >= {3'b0, root}) ? dv_shift - {3'b0, root} : dv_shift;
          quo <= quo_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(OUT_FRAC-1)) begin
            fin_distance <= dot[ACC_BITS-1] ? ONE_OUT + ACC_BITS'(quo_next)
                                            : ONE_OUT - ACC_BITS'(quo_next);
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/vector_distance_threshold_match_core.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// input     | push / full                | query_element, row_element, last_element
// result    | pop / empty                | match, distance
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// element pairs enter at one per cycle while full is low; the product stage and
// running sums sustain that rate. a cosine result passes through 48 multiply
// steps, 48 root steps and 24 divide steps, and skips the divide when |dot|
// reaches the root; a zero norm and the other metrics go straight to the result.
// a two-entry queue of finished sums lets the front keep accepting while the
// finisher works; full rises only when that queue is full and the product stage
// holds a last pair. an unpopped result holds the finisher. synchronous reset
// clears sums and control.
module vector_distance_threshold_match_core import vdtm_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [ELEMENT_BITS-1:0] query_element,
  input  logic signed [ELEMENT_BITS-1:0] row_element,
  input  logic                           last_element,
  output logic                           empty,
  input  logic                           pop,
  output logic                           match,
  output logic signed [ACC_BITS-1:0]     distance,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [ACC_BITS-1:0]            cfg_data
);

  kind_t                      metric_kind;
  logic signed [ACC_BITS-1:0] match_threshold;

  // sums handed from accumulator to finisher
  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_empty;
  sums_t q_wr_data;
  sums_t q_rd_data;

  // config writes are always accepted and land in the cycle after cfg_valid
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_kind     <= KIND_COSINE;
      match_threshold <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KIND:      metric_kind     <= kind_t'(cfg_data[1:0]);
        REG_THRESHOLD: match_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: multiply and accumulate each pair, hand over sums on the last pair
  vdtm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .query_element (query_element),
    .row_element   (row_element),
    .last_element  (last_element),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_data        (q_wr_data)
  );

  vdtm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .is_full  (q_full),
    .rd       (q_rd),
    .rd_data  (q_rd_data),
    .is_empty (q_empty)
  );

  // back: metric finisher with root and divide, plus the result register
  vdtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_rd      (q_rd),
    .kind      (metric_kind),
    .threshold (match_threshold),
    .empty     (empty),
    .pop       (pop),
    .match     (match),
    .distance  (distance)
  );

endmodule

// ----- tb/sv/vector_distance_threshold_match_core_tb.sv -----
module vector_distance_threshold_match_core_tb;
  import vdtm_pkg::*;

  // spare register slots, the block ignores writes to them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);
  localparam int SETTLE_CYCLES = 200;   // wait after draining before the next phase
  localparam int STALL_LIMIT   = 3000;  // cycles without any transaction

  typedef struct {
    logic signed [ELEMENT_BITS-1:0] q;
    logic signed [ELEMENT_BITS-1:0] r;
    logic                           last;
  } pair_t;

  typedef struct {
    logic                       match;
    logic signed [ACC_BITS-1:0] distance;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [ELEMENT_BITS-1:0] query_element = '0;
  logic signed [ELEMENT_BITS-1:0] row_element = '0;
  logic last_element = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic match;
  logic signed [ACC_BITS-1:0] distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [ACC_BITS-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  vector_distance_threshold_match_core DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .query_element(query_element), .row_element(row_element),
    .last_element(last_element), .empty(empty), .pop(pop),
    .match(match), .distance(distance), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // stimulus and scoreboard storage
  pair_t    pending_pairs[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  int pairs_sent = 0;
  int verdicts_checked = 0;
  int cfg_writes = 0;
  bit calm_mode = 0;     // when set, neither side idles
  bit pair_taken = 0;
  int push_gap = 0;
  int pop_gap = 0;
  int quiet_cycles = 0;

  // predictor copy of the block's registers and running sums
  kind_t                      kind_shadow = KIND_COSINE;
  logic signed [ACC_BITS-1:0] threshold_shadow = '0;
  logic signed [ACC_BITS-1:0] dot_acc = '0;
  logic signed [ACC_BITS-1:0] qnorm_acc = '0;
  logic signed [ACC_BITS-1:0] rnorm_acc = '0;

  function automatic longint clamp48(longint v);
    longint hi, lo;
    hi = longint'(ACC_MAX);
    lo = longint'(ACC_MIN);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // 1 - dot / sqrt(|q|^2 |r|^2) in Q.24, exact integer root and long division
  function automatic longint cosine_gap(longint dot, longint qn, longint rn);
    logic [95:0] prod, trial;
    longint unsigned root, mag, rem, quo, one;
    longint d;
    one = longint'(ONE_OUT);
    if (qn <= 0 || rn <= 0) return one;
    prod = 96'(qn) * 96'(rn);
    root = 0;
    for (int b = ACC_BITS - 1; b >= 0; b--) begin
      trial = 96'(root | (64'd1 << b));
      if (trial * trial <= prod) root = root | (64'd1 << b);
    end
    if (root == 0) return one;
    mag = (dot < 0) ? -dot : dot;
    quo = 0;
    if (mag >= root) begin
      quo = one;
    end else begin
      rem = mag;
      for (int i = 0; i < OUT_FRAC; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= root) begin
          rem = rem - root;
          quo = quo | 1;
        end
      end
    end
    d = (dot >= 0) ? one - longint'(quo) : one + longint'(quo);
    return (d < 0) ? 0 : d;
  endfunction

  // fold one pair into the sums; on the last pair push the expected verdict, if the metric gives one
  task automatic accumulate_pair(pair_t p);
    longint qv, rv, d;
    verdict_t v;
    bit emits;
    qv = longint'(p.q);
    rv = longint'(p.r);
    dot_acc   = clamp48(longint'(dot_acc) + qv * rv);
    qnorm_acc = clamp48(longint'(qnorm_acc) + qv * qv);
    rnorm_acc = clamp48(longint'(rnorm_acc) + rv * rv);
    if (!p.last) return;
    emits = 1;
    d = 0;
    case (kind_shadow)
      KIND_COSINE: d = cosine_gap(dot_acc, qnorm_acc, rnorm_acc);
      KIND_INNER:  d = clamp48(-longint'(dot_acc));
      KIND_L2: begin
        d = longint'(qnorm_acc) + longint'(rnorm_acc) - 2 * longint'(dot_acc);
        if (d < 0) d = 0;
        d = clamp48(d);
      end
      default: emits = 0;
    endcase
    dot_acc = '0;
    qnorm_acc = '0;
    rnorm_acc = '0;
    if (emits) begin
      v.distance = ACC_BITS'(d);
      v.match = (d <= longint'(threshold_shadow));
      expected_verdicts.push_back(v);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic int pick_gap();
    int roll;
    if (calm_mode) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // rising edge: record accepted transactions and check results
  always @(posedge clk) begin
    verdict_t want;
    pair_t got;
    bit active;
    active = 0;
    if (!rst && push && !full) begin
      got.q = query_element;
      got.r = row_element;
      got.last = last_element;
      accumulate_pair(got);
      pair_taken = 1;
      pairs_sent++;
      active = 1;
    end
    if (!rst && pop && !empty) begin
      active = 1;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%0d match=%0b",
                                  distance, match));
      end else begin
        want = expected_verdicts.pop_front();
        if (distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    distance, want.distance));
        if (match !== want.match)
          report_mismatch($sformatf("match %0b, expected %0b (distance %0d)",
                                    match, want.match, want.distance));
        verdicts_checked++;
      end
    end
    if (!rst && cfg_valid && cfg_ready) begin
      active = 1;
      cfg_writes++;
      if (cfg_index == REG_KIND) kind_shadow = kind_t'(cfg_data[1:0]);
      else if (cfg_index == REG_THRESHOLD) threshold_shadow = cfg_data;
    end
    // watchdog: too long without any transaction means the block is stuck
    quiet_cycles = active ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // falling edge: element pair driver, holds push until the pair is taken
  always @(negedge clk) begin
    pair_t nxt;
    if (!rst && !(push && !pair_taken)) begin
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        nxt = pending_pairs.pop_front();
        query_element <= nxt.q;
        row_element <= nxt.r;
        last_element <= nxt.last;
        push <= 1'b1;
        push_gap = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
    pair_taken = 0;
  end

  // falling edge: result consumer with random stalls
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap = pick_gap();
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [ACC_BITS-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every pair and expected result to drain, then let the finisher settle
  task automatic drain();
    do @(posedge clk); while (pending_pairs.size() > 0 || push ||
                              expected_verdicts.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [ELEMENT_BITS-1:0] pick_element();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return ELEMENT_BITS'($signed($urandom_range(0, 8192)) - 4096);
      default: return ELEMENT_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_pair(logic signed [ELEMENT_BITS-1:0] q,
                            logic signed [ELEMENT_BITS-1:0] r, logic last);
    pair_t p;
    p.q = q;
    p.r = r;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  task automatic queue_random_vectors(int count);
    int len;
    logic signed [ELEMENT_BITS-1:0] q;
    for (int v = 0; v < count; v++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        q = pick_element();
        // sometimes parallel or opposite vectors to hit the cosine edges
        case ($urandom_range(5))
          0: queue_pair(q, q, i == len - 1);
          1: queue_pair(q, -q, i == len - 1);
          default: queue_pair(q, pick_element(), i == len - 1);
        endcase
      end
    end
  endtask

  task automatic queue_directed();
    queue_pair(16'sh7fff, 16'sh7fff, 1'b1);   // largest positive pair
    queue_pair(16'sh8000, 16'sh8000, 1'b1);   // most negative pair
    queue_pair(16'sh8000, 16'sh7fff, 1'b1);   // opposite signs
    queue_pair(16'sh0000, 16'sh0000, 1'b1);   // both norms zero
    queue_pair(16'sh1000, 16'sh0000, 1'b1);   // row norm zero
    queue_pair(16'sh0000, 16'sh1000, 1'b0);   // query norm zero over two pairs
    queue_pair(16'sh0000, 16'sh2000, 1'b1);
    queue_pair(16'sh1000, 16'sh0000, 1'b0);   // orthogonal
    queue_pair(16'sh0000, 16'sh1000, 1'b1);
    queue_pair(16'sh0001, 16'shffff, 1'b0);   // tiny mixed values
    queue_pair(16'sh5555, 16'shaaaa, 1'b1);
  endtask

  // one phase per register setting; extremes of the threshold included
  task automatic run_phase(kind_t k, logic signed [ACC_BITS-1:0] thr, int vectors);
    write_reg(REG_KIND, ACC_BITS'(k));
    write_reg(REG_THRESHOLD, thr);
    calm_mode = ($urandom_range(3) == 0);
    queue_directed();
    queue_random_vectors(vectors);
    drain();
  endtask

  initial begin
    logic signed [ACC_BITS-1:0] rnd_thr;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // spare slots must not disturb the real registers
    write_reg(REG_SPARE_A, {ACC_BITS{1'b1}});
    write_reg(REG_SPARE_B, {ACC_BITS{1'b1}});
    run_phase(KIND_COSINE, '0, 8);
    run_phase(KIND_COSINE, ONE_OUT >>> 1, 8);
    run_phase(KIND_INNER, ACC_MAX, 6);
    run_phase(KIND_INNER, ACC_MIN, 6);
    run_phase(KIND_L2, ACC_BITS'(64'd1 << 27), 6);
    run_phase(KIND_NONE, '0, 5);            // no results, sums still cleared
    rnd_thr = ACC_BITS'({$urandom, $urandom});
    run_phase(KIND_COSINE, rnd_thr, 6);
    $display("covered %0d element pairs, %0d checked results, %0d register writes",
             pairs_sent, verdicts_checked, cfg_writes);
    $display("metrics cosine, inner product, squared l2 and the unused code; %0d errors",
             errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/vdtm_pkg.sv
hdl/vdtm_front.sv
hdl/vdtm_queue.sv
hdl/vdtm_back.sv
hdl/vector_distance_threshold_match_core.sv
tb/sv/vector_distance_threshold_match_core_tb.sv
